@@ rtl/core/command_frame_deframer_macros.svh @@
// assertion macros for the command frame deframer
`ifndef COMMAND_FRAME_DEFRAMER_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define CFD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("deframer check failed");
`define CFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
`else
`define CFD_ASSERT_NEVER(label, clk, rst_n, cond)
`define CFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/cfd_pkg.sv @@
// shared types and constants of the command frame deframer
package cfd_pkg;

    localparam int MAX_PAYLOAD = 8;
    localparam int HDR_BYTES   = 5;
    localparam int SERVO_LEN   = 4;
    localparam int LED_LEN     = 1;

    localparam int HDR_CNT_W = $clog2(HDR_BYTES);
    localparam int PCNT_W    = $clog2(MAX_PAYLOAD + 1);
    localparam int STORE_IW  = $clog2(SERVO_LEN);
    localparam int LEN_W     = 32;

    localparam logic [7:0] SERVO_CODE_RST = 8'h22;
    localparam logic [7:0] LED_CODE_RST   = 8'h23;

    localparam logic [7:0] CFG_SERVO_CODE = 8'd0;
    localparam logic [7:0] CFG_LED_CODE   = 8'd1;

    typedef enum logic [1:0] {
        EV_SERVO = 2'd0,
        EV_LED   = 2'd1,
        EV_ERROR = 2'd2
    } t_event;

    typedef struct packed {
        logic [7:0] servo_code;
        logic [7:0] led_code;
    } t_cfg;

    typedef struct packed {
        t_event      event_res;
        logic [15:0] pan;
        logic [15:0] tilt;
        logic        led_on;
    } t_result;

endpackage

@@ rtl/core/cfd_cfg_regs.sv @@
// configuration registers holding the command type codes
module cfd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output logic          o_cfg_ready,
    output cfd_pkg::t_cfg o_cfg
);
    import cfd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SERVO_CODE: n_cfg.servo_code = i_cfg_data;
                CFG_LED_CODE:   n_cfg.led_code   = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.servo_code <= SERVO_CODE_RST;
            r_cfg.led_code   <= LED_CODE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

@@ rtl/core/cfd_parser.sv @@
// input byte register and frame parsing state
`include "command_frame_deframer_macros.svh"
module cfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cfd_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_res_ready,
    output logic             o_res_valid,
    output cfd_pkg::t_result o_res
);
    import cfd_pkg::*;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_payload;
    logic [HDR_CNT_W-1:0] r_hdr_cnt;
    logic [7:0]           r_frm_type;
    logic [LEN_W-1:0]     r_frm_len;
    logic [PCNT_W-1:0]    r_pcnt;
    logic [7:0]           r_store [SERVO_LEN];

    logic                 n_in_payload;
    logic [HDR_CNT_W-1:0] n_hdr_cnt;
    logic [7:0]           n_frm_type;
    logic [LEN_W-1:0]     n_frm_len;
    logic [PCNT_W-1:0]    n_pcnt;

    logic                 w_adv;
    logic                 w_res_hit;
    logic [PCNT_W-1:0]    w_pcnt_inc;
    t_result              w_res;

    assign w_adv      = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;
    assign w_pcnt_inc = r_pcnt + 1'b1;

    // frame state update for the byte in the input register
    always_comb begin
        n_in_payload  = r_in_payload;
        n_hdr_cnt     = r_hdr_cnt;
        n_frm_type    = r_frm_type;
        n_frm_len     = r_frm_len;
        n_pcnt        = r_pcnt;
        w_res_hit     = 1'b0;
        w_res         = '0;
        w_res.event_res = EV_SERVO;
        if (!r_in_payload) begin
            if (r_hdr_cnt == '0) begin
                n_frm_type = r_in_byte;
                n_frm_len  = '0;
            end else begin
                n_frm_len = {r_frm_len[LEN_W-9:0], r_in_byte};
            end
            if (r_hdr_cnt == HDR_CNT_W'(HDR_BYTES - 1)) begin
                n_hdr_cnt = '0;
                n_pcnt    = '0;
                if (n_frm_len > LEN_W'(MAX_PAYLOAD)) begin
                    w_res_hit       = 1'b1;
                    w_res.event_res = EV_ERROR;
                end else if (n_frm_len != '0) begin
                    n_in_payload = 1'b1;
                end
            end else begin
                n_hdr_cnt = r_hdr_cnt + 1'b1;
            end
        end else begin
            n_pcnt = w_pcnt_inc;
            if (LEN_W'(w_pcnt_inc) >= r_frm_len) begin
                n_in_payload = 1'b0;
                n_pcnt       = '0;
                if (r_frm_type == i_cfg.servo_code && r_frm_len == LEN_W'(SERVO_LEN)) begin
                    w_res_hit       = 1'b1;
                    w_res.event_res = EV_SERVO;
                    w_res.pan       = {r_store[0], r_store[1]};
                    w_res.tilt      = {r_store[2], r_in_byte};
                end else if (r_frm_type == i_cfg.led_code &&
                             r_frm_len == LEN_W'(LED_LEN)) begin
                    w_res_hit       = 1'b1;
                    w_res.event_res = EV_LED;
                    w_res.led_on    = (r_in_byte == 8'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_frm_type   <= '0;
            r_frm_len    <= '0;
            r_pcnt       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_in_payload <= n_in_payload;
                r_hdr_cnt    <= n_hdr_cnt;
                r_frm_type   <= n_frm_type;
                r_frm_len    <= n_frm_len;
                r_pcnt       <= n_pcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_adv && r_in_payload && r_pcnt < PCNT_W'(SERVO_LEN)) begin
            r_store[r_pcnt[STORE_IW-1:0]] <= r_in_byte;
        end
    end

    assign o_res_valid = w_adv && w_res_hit;
    assign o_res       = w_res;

    `CFD_ASSERT_NEVER(a_hdr_idle_in_payload, i_clk, i_rst_n, r_in_payload && r_hdr_cnt != '0)
    `CFD_ASSERT_IMPL(a_payload_len_ok, i_clk, i_rst_n, r_in_payload,
        r_frm_len != '0 && r_frm_len <= LEN_W'(MAX_PAYLOAD) && LEN_W'(r_pcnt) < r_frm_len)
    `CFD_ASSERT_IMPL(a_error_fields_zero, i_clk, i_rst_n,
        o_res_valid && o_res.event_res == EV_ERROR,
        o_res.pan == '0 && o_res.tilt == '0 && !o_res.led_on)

endmodule

@@ rtl/core/cfd_out_reg.sv @@
// result register toward the output channel
module cfd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_valid,
    input  cfd_pkg::t_result i_load_res,
    output logic             o_can_load,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output cfd_pkg::t_result o_res
);
    import cfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load_valid) begin
            r_res <= i_load_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

@@ rtl/core/command_frame_deframer.sv @@
// top level of the command frame deframer
// output path: a result is shown once its last byte has passed the input register
// and then the result register, which loads it when empty or while it is being read
// throughput: one byte per cycle, set by the single-pass parse step, unless a held output result stalls the input
// reset: synchronous active low; clears parsing state, type codes go to 0x22 and 0x23
module command_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic [15:0] o_pan,
    output logic [15:0] o_tilt,
    output logic        o_led_on,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import cfd_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    t_result w_out_res;
    logic    w_res_valid;
    logic    w_can_load;

    cfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    cfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_res_ready (w_can_load),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cfd_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (w_res_valid),
        .i_load_res   (w_res),
        .o_can_load   (w_can_load),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_res        (w_out_res)
    );

    assign o_event_res = w_out_res.event_res;
    assign o_pan       = w_out_res.pan;
    assign o_tilt      = w_out_res.tilt;
    assign o_led_on    = w_out_res.led_on;

endmodule
